FILE: design/rdf_pkg.sv
// Shared types and constants of the radix digit formatter.
package rdf_pkg;

  localparam int VALUE_W     = 64;
  localparam int SYMBOL_W    = 8;
  localparam int COUNT_W     = 7;
  localparam int DIGIT_W     = 6;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 4;
  localparam int NUM_REGS    = 8;
  localparam int REG_SEL_W   = 3;
  localparam int DIV_BITS    = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SYMBOL_W-1:0] SYM_LOW   = 8'd32;
  localparam logic [SYMBOL_W-1:0] SYM_HIGH  = 8'd126;
  localparam logic [SYMBOL_W-1:0] SYM_PLUS  = 8'd43;
  localparam logic [SYMBOL_W-1:0] SYM_MINUS = 8'd45;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] radix;
  } rdf_job_t;

endpackage

FILE: design/rdf_ram.sv
// Generic single write port RAM with a registered read port.
module rdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/rdf_front.sv
// Front end: accepts a value and checks the symbol table, producing a job.
module rdf_front #(
  parameter int TABLE_BYTES = 64,
  parameter int VALUE_BITS  = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [TABLE_BYTES*8-1:0] tbl,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [VALUE_BITS-1:0]    in_value,
  output logic                     push_valid,
  input  logic                     push_full,
  output rdf_pkg::rdf_job_t        push_job,
  output logic [VALUE_BITS-1:0]    push_value
);
  import rdf_pkg::*;

  localparam int IDXW = $clog2(TABLE_BYTES);

  typedef enum logic [1:0] {F_IDLE, F_SCAN, F_PUSH} state_t;

  state_t                  state_r;
  logic [VALUE_BITS-1:0]   value_r;
  logic [IDXW-1:0]         idx_r;
  logic [127:0]            seen_r;
  logic [COUNT_W-1:0]      len_r;
  logic                    bad_r;
  logic [SYMBOL_W-1:0]     c;
  logic                    c_bad;

  assign c = tbl[idx_r*8 +: 8];
  assign c_bad = (c < SYM_LOW) || (c > SYM_HIGH) || (c == SYM_PLUS) ||
                 (c == SYM_MINUS) || seen_r[c[6:0]];

  assign in_stall       = (state_r != F_IDLE);
  assign push_valid     = (state_r == F_PUSH);
  assign push_job.ok    = !bad_r && (len_r >= COUNT_W'(2));
  assign push_job.radix = len_r;
  assign push_value     = value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            value_r <= in_value;
            idx_r   <= '0;
            seen_r  <= '0;
            bad_r   <= 1'b0;
            state_r <= F_SCAN;
          end
        end
        F_SCAN: begin
          if (c == '0) begin
            len_r   <= COUNT_W'(idx_r);
            state_r <= F_PUSH;
          end else if (c_bad) begin
            bad_r   <= 1'b1;
            state_r <= F_PUSH;
          end else begin
            seen_r[c[6:0]] <= 1'b1;
            if (idx_r == IDXW'(TABLE_BYTES - 1)) begin
              len_r   <= COUNT_W'(TABLE_BYTES);
              state_r <= F_PUSH;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        F_PUSH: begin
          if (!push_full) begin
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/rdf_queue.sv
// Short register queue that decouples the front end from the back end.
module rdf_queue #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_full,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_take,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW:0]      count_r;
  logic             do_push;
  logic             do_pop;

  assign push_full = (count_r == (AW+1)'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop_take && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: design/rdf_back.sv
// Back end: divides out the digits into a stack and emits them as symbols, or emits one error beat for a bad job.
module rdf_back #(
  parameter int TABLE_BYTES = 64,
  parameter int VALUE_BITS  = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [TABLE_BYTES*8-1:0]          tbl,
  input  logic                              q_valid,
  output logic                              q_take,
  input  rdf_pkg::rdf_job_t                 q_job,
  input  logic [VALUE_BITS-1:0]             q_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rdf_pkg::SYMBOL_W-1:0]      out_symbol,
  output logic                              out_last_symbol,
  output logic                              out_base_ok,
  output logic [rdf_pkg::COUNT_W-1:0]       out_symbol_total
);
  import rdf_pkg::*;

  localparam int IDXW  = $clog2(TABLE_BYTES);
  localparam int AW    = $clog2(VALUE_BITS);
  localparam int STEPS = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int PADW  = STEPS * DIV_BITS;
  localparam int STW   = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef enum logic [2:0] {B_IDLE, B_DIV, B_EMIT_RD, B_EMIT_LD, B_ERR} state_t;

  state_t                 state_r;
  logic [PADW-1:0]        work_r;
  logic [COUNT_W-1:0]     radix_r;
  logic [COUNT_W-1:0]     rem_r;
  logic [STW-1:0]         step_r;
  logic [COUNT_W-1:0]     cnt_r;
  logic [AW-1:0]          ptr_r;
  logic                   out_valid_r;
  logic [SYMBOL_W-1:0]    symbol_r;
  logic                   last_r;
  logic                   ok_r;
  logic [COUNT_W-1:0]     total_r;

  logic [COUNT_W-1:0]     rem_nxt;
  logic [DIV_BITS-1:0]    qbits;
  logic [PADW+DIV_BITS-1:0] wshift;
  logic                   out_free;
  logic                   emit_go;
  logic                   div_done;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [DIGIT_W-1:0]     ram_rdata;
  logic [SYMBOL_W-1:0]    emit_sym;

  // Restoring division of one byte of the value per cycle.
  always_comb begin
    logic [COUNT_W-1:0] r;
    r     = rem_r;
    qbits = '0;
    for (int j = 0; j < DIV_BITS; j++) begin
      r = {r[COUNT_W-2:0], work_r[PADW-1-j]};
      if (r >= radix_r) begin
        r = r - radix_r;
        qbits[DIV_BITS-1-j] = 1'b1;
      end
    end
    rem_nxt = r;
  end

  assign wshift   = {work_r, qbits};
  assign out_free = !out_valid_r || !out_stall;
  assign emit_go  = ((state_r == B_EMIT_LD) || (state_r == B_ERR)) && out_free;
  assign div_done = (state_r == B_DIV) && (step_r == STW'(STEPS - 1));
  assign q_take   = (state_r == B_IDLE) && q_valid;
  assign emit_sym = tbl[ram_rdata[IDXW-1:0]*8 +: 8];

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = ptr_r;
    case (state_r)
      B_EMIT_RD: begin
        ram_re = 1'b1;
      end
      B_EMIT_LD: begin
        if (out_free && (ptr_r != '0)) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_r - 1'b1;
        end
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  rdf_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(VALUE_BITS)
  ) u_stack (
    .clk   (clk),
    .we    (div_done),
    .waddr (cnt_r[AW-1:0]),
    .wdata (rem_nxt[DIGIT_W-1:0]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            work_r  <= PADW'(q_value);
            radix_r <= q_job.radix;
            rem_r   <= '0;
            step_r  <= '0;
            cnt_r   <= '0;
            state_r <= q_job.ok ? B_DIV : B_ERR;
          end
        end
        B_DIV: begin
          work_r <= wshift[PADW-1:0];
          if (div_done) begin
            cnt_r  <= cnt_r + 1'b1;
            rem_r  <= '0;
            step_r <= '0;
            if (wshift[PADW-1:0] == '0) begin
              ptr_r   <= cnt_r[AW-1:0];
              state_r <= B_EMIT_RD;
            end
          end else begin
            step_r <= step_r + 1'b1;
            rem_r  <= rem_nxt;
          end
        end
        B_EMIT_RD: begin
          state_r <= B_EMIT_LD;
        end
        B_EMIT_LD: begin
          if (out_free) begin
            symbol_r    <= emit_sym;
            last_r      <= (ptr_r == '0);
            ok_r        <= 1'b1;
            total_r     <= (ptr_r == '0) ? cnt_r : '0;
            if (ptr_r == '0) begin
              state_r <= B_IDLE;
            end else begin
              ptr_r <= ptr_r - 1'b1;
            end
          end
        end
        B_ERR: begin
          if (out_free) begin
            symbol_r    <= '0;
            last_r      <= 1'b1;
            ok_r        <= 1'b0;
            total_r     <= '0;
            state_r     <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_symbol       = symbol_r;
  assign out_last_symbol  = last_r;
  assign out_base_ok      = ok_r;
  assign out_symbol_total = total_r;

endmodule

FILE: design/radix_digit_formatter_top.sv
// The front end checks the symbol table one table byte at a time (up to TABLE_BYTES).
// The back end divides one byte of the value per cycle, in ceil(VALUE_BITS/8) steps per digit.
// Symbols leave at one beat per cycle while out_stall is low, after B_EMIT_RD starts the stack read.
// A queue of two jobs lets the front end check the next value while digits are emitted.
// Reset is synchronous and active low; it clears the symbol registers, state machines, queue and out_valid.
// The digit stack is not cleared; it is always written before it is read.
module radix_digit_formatter_top #(
  parameter int TABLE_BYTES = 64,
  parameter int VALUE_BITS  = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rdf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rdf_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rdf_pkg::VALUE_W-1:0]     in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rdf_pkg::SYMBOL_W-1:0]    out_symbol,
  output logic                            out_last_symbol,
  output logic                            out_base_ok,
  output logic [rdf_pkg::COUNT_W-1:0]     out_symbol_total
);
  import rdf_pkg::*;

  localparam int QW = VALUE_BITS + $bits(rdf_job_t);

  logic [CFG_W-1:0]         sym_r [NUM_REGS];
  logic [TABLE_BYTES*8-1:0] tbl;
  logic                     push_valid;
  logic                     push_full;
  rdf_job_t                 push_job;
  logic [VALUE_BITS-1:0]    push_value;
  logic                     pop_valid;
  logic                     pop_take;
  logic [QW-1:0]            pop_data;
  rdf_job_t                 pop_job;
  logic [VALUE_BITS-1:0]    pop_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        sym_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      sym_r[cfg_index[REG_SEL_W-1:0]] <= cfg_wdata;
    end
  end

  for (genvar g = 0; g < TABLE_BYTES; g++) begin : g_tbl
    assign tbl[g*8 +: 8] = sym_r[g/8][(g%8)*8 +: 8];
  end

  rdf_front #(
    .TABLE_BYTES(TABLE_BYTES),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .tbl        (tbl),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value[VALUE_BITS-1:0]),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_job   (push_job),
    .push_value (push_value)
  );

  rdf_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_data  ({push_job, push_value}),
    .pop_valid  (pop_valid),
    .pop_take   (pop_take),
    .pop_data   (pop_data)
  );

  assign pop_job   = pop_data[QW-1 -: $bits(rdf_job_t)];
  assign pop_value = pop_data[VALUE_BITS-1:0];

  rdf_back #(
    .TABLE_BYTES(TABLE_BYTES),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .tbl              (tbl),
    .q_valid          (pop_valid),
    .q_take           (pop_take),
    .q_job            (pop_job),
    .q_value          (pop_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_symbol       (out_symbol),
    .out_last_symbol  (out_last_symbol),
    .out_base_ok      (out_base_ok),
    .out_symbol_total (out_symbol_total)
  );

endmodule

FILE: design/rdf_checker.sv
// Port level checks of the radix digit formatter and their bind.
module rdf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [rdf_pkg::SYMBOL_W-1:0]    out_symbol,
  input logic                            out_last_symbol,
  input logic                            out_base_ok,
  input logic [rdf_pkg::COUNT_W-1:0]     out_symbol_total
);

  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Input was not held off after an accepted beat.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol) &&
      $stable(out_last_symbol) && $stable(out_symbol_total))
    else $error("Stalled output beat changed.");

  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_base_ok |-> out_last_symbol && (out_symbol == '0) &&
      (out_symbol_total == '0))
    else $error("Error beat is malformed.");

  a_total_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_symbol |-> out_base_ok && (out_symbol_total == '0))
    else $error("Inner beat carries a count or an error.");

  a_total_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_symbol && out_base_ok |-> (out_symbol_total != '0))
    else $error("Final beat of a valid base has no count.");

endmodule

bind radix_digit_formatter_top rdf_checker u_rdf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_symbol       (out_symbol),
  .out_last_symbol  (out_last_symbol),
  .out_base_ok      (out_base_ok),
  .out_symbol_total (out_symbol_total)
);
